// ===== sv/atpr_pkg.sv =====
// ----------------------------------------------------------------------------
// atpr_pkg
// Shared constants, types and the CORDIC angle table for the tilt block.
// ----------------------------------------------------------------------------
package atpr_pkg;

    // Number of configuration registers and their index codes.
    localparam int CFG_COUNT = 6;
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_POS = 3'd0,
        CFG_X_NEG = 3'd1,
        CFG_Y_POS = 3'd2,
        CFG_Y_NEG = 3'd3,
        CFG_Z_POS = 3'd4,
        CFG_Z_NEG = 3'd5
    } t_cfg_idx;

    localparam int DIV_W        = 12;
    localparam int DIV_RESET    = 256;
    localparam int AXIS_W       = 16;
    localparam int ANGLE_W      = 16;
    localparam int G_FRAC_DEF   = 12;
    localparam int ANG_FRAC_DEF = 8;

    // CORDIC geometry.
    localparam int CORDIC_STEPS = 20;
    localparam int TBL_FRAC     = 16;
    // x holds up to sqrt(2)*2^15*2^8*2^8*1.65 < 2^41; y up to 2^31.
    localparam int CRD_W        = 44;
    localparam int ZACC_W       = 24;

    // Sum of two squares of 16-bit values, then shifted by 16.
    localparam int SQ_W   = 31;
    localparam int RAD_W  = SQ_W + 16;
    localparam int ROOT_W = 24;

    // atan(2^-i) in units of 2^-16 degree.
    function automatic logic [ZACC_W-1:0] atan_entry(input logic [4:0] idx);
        logic [ZACC_W-1:0] v;
        case (idx)
            5'd0:  v = 24'd2949120;
            5'd1:  v = 24'd1740967;
            5'd2:  v = 24'd919879;
            5'd3:  v = 24'd466945;
            5'd4:  v = 24'd234379;
            5'd5:  v = 24'd117304;
            5'd6:  v = 24'd58666;
            5'd7:  v = 24'd29335;
            5'd8:  v = 24'd14668;
            5'd9:  v = 24'd7334;
            5'd10: v = 24'd3667;
            5'd11: v = 24'd1833;
            5'd12: v = 24'd917;
            5'd13: v = 24'd458;
            5'd14: v = 24'd229;
            5'd15: v = 24'd115;
            5'd16: v = 24'd57;
            5'd17: v = 24'd29;
            5'd18: v = 24'd14;
            5'd19: v = 24'd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/atpr_div.sv =====
// ----------------------------------------------------------------------------
// atpr_div
// Pipelined restoring divider: one quotient bit per stage, sign-magnitude,
// truncation toward zero, saturation to a signed 16-bit result.
// ----------------------------------------------------------------------------
module atpr_div
    import atpr_pkg::*;
#(
    parameter int G_FRAC_BITS = G_FRAC_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [AXIS_W-1:0] i_count,
    input  logic [DIV_W-1:0]         i_pos_div,
    input  logic [DIV_W-1:0]         i_neg_div,
    output logic signed [AXIS_W-1:0] o_quot
);
    // Dividend magnitude is |count| << G_FRAC_BITS.
    localparam int NUM_W = AXIS_W + G_FRAC_BITS;
    localparam int REM_W = DIV_W + 1;

    logic [NUM_W-1:0] r_num [NUM_W+1];
    logic [REM_W-1:0] r_rem [NUM_W+1];
    logic [DIV_W-1:0] r_div [NUM_W+1];
    logic             r_neg [NUM_W+1];
    logic             r_pos [NUM_W+1];
    logic             r_dz  [NUM_W+1];

    logic [AXIS_W-1:0] n_mag;
    logic [DIV_W-1:0]  n_d;

    // Select the divisor by sign and take the magnitude.
    always_comb begin
        n_d   = (i_count > 0) ? i_pos_div : i_neg_div;
        n_mag = i_count[AXIS_W-1] ? (~i_count + 1'b1) : i_count;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0] <= {n_mag, {G_FRAC_BITS{1'b0}}};
            r_rem[0] <= '0;
            r_div[0] <= n_d;
            r_neg[0] <= i_count[AXIS_W-1];
            r_pos[0] <= (i_count > 0);
            r_dz[0]  <= (n_d == '0);
        end
    end

    // One quotient bit per stage; the quotient shifts into the numerator.
    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        logic [REM_W-1:0] w_trial;
        logic             w_ge;
        assign w_trial = {r_rem[s][REM_W-2:0], r_num[s][NUM_W-1]};
        assign w_ge    = (w_trial >= {1'b0, r_div[s]});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= w_ge ? (w_trial - {1'b0, r_div[s]}) : w_trial;
                r_num[s+1] <= {r_num[s][NUM_W-2:0], w_ge};
                r_div[s+1] <= r_div[s];
                r_neg[s+1] <= r_neg[s];
                r_pos[s+1] <= r_pos[s];
                r_dz[s+1]  <= r_dz[s];
            end
        end
    end

    // Sign and saturation.
    always_comb begin
        if (r_dz[NUM_W]) begin
            o_quot = r_pos[NUM_W] ? 16'sh7fff : (r_neg[NUM_W] ? -16'sh8000 : '0);
        end else if (r_neg[NUM_W]) begin
            o_quot = (r_num[NUM_W] > NUM_W'(32768)) ? -16'sh8000
                   : AXIS_W'(~r_num[NUM_W] + 1'b1);
        end else begin
            o_quot = (r_num[NUM_W] > NUM_W'(32767)) ? 16'sh7fff
                   : AXIS_W'(r_num[NUM_W]);
        end
    end

endmodule

// ===== sv/atpr_sqrt.sv =====
// ----------------------------------------------------------------------------
// atpr_sqrt
// Pipelined integer square root of the sum of two squares, shifted by 16.
// One result bit per stage.
// ----------------------------------------------------------------------------
module atpr_sqrt
    import atpr_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [AXIS_W-1:0] i_p,
    input  logic signed [AXIS_W-1:0] i_q,
    output logic [ROOT_W-1:0]        o_root
);
    localparam int RW = RAD_W + 1;

    logic [SQ_W-1:0] r_pp, r_qq;
    logic [RW-1:0]   r_rad  [ROOT_W+1];
    logic [RW-1:0]   r_rem  [ROOT_W+1];
    logic [ROOT_W-1:0] r_res [ROOT_W+1];

    // Squares are registered before the sum.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp <= SQ_W'($unsigned((2*AXIS_W)'(i_p) * (2*AXIS_W)'(i_p)));
            r_qq <= SQ_W'($unsigned((2*AXIS_W)'(i_q) * (2*AXIS_W)'(i_q)));
            r_rad[0] <= {({1'b0, r_pp} + {1'b0, r_qq}), 16'd0};
            r_rem[0] <= '0;
            r_res[0] <= '0;
        end
    end

    // Digit-by-digit root: bring in two radicand bits per stage.
    for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
        logic [RW-1:0] w_rem;
        logic [RW-1:0] w_trial;
        logic          w_ge;
        assign w_rem   = {r_rem[s][RW-3:0], r_rad[s][RW-1:RW-2]};
        assign w_trial = {r_res[s], 2'b01};
        assign w_ge    = (w_rem >= w_trial);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[s+1] <= {r_rad[s][RW-3:0], 2'b00};
                r_rem[s+1] <= w_ge ? (w_rem - w_trial) : w_rem;
                r_res[s+1] <= {r_res[s][ROOT_W-2:0], w_ge};
            end
        end
    end

    assign o_root = r_res[ROOT_W];

endmodule

// ===== sv/atpr_cordic.sv =====
// ----------------------------------------------------------------------------
// atpr_cordic
// Pipelined vectoring CORDIC: one micro-rotation per stage, followed by
// rounding, clamping and the zero special cases.
// ----------------------------------------------------------------------------
module atpr_cordic
    import atpr_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANG_FRAC_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [AXIS_W-1:0]  i_a,
    input  logic [ROOT_W-1:0]         i_b,
    output logic signed [ANGLE_W-1:0] o_angle
);
    localparam int SH    = TBL_FRAC - ANGLE_FRAC_BITS;
    localparam int LIMIT = 90 * (1 << ANGLE_FRAC_BITS);

    logic signed [CRD_W-1:0]  r_x [CORDIC_STEPS+1];
    logic signed [CRD_W-1:0]  r_y [CORDIC_STEPS+1];
    logic signed [ZACC_W+1:0] r_z [CORDIC_STEPS+1];
    logic                     r_az [CORDIC_STEPS+1];
    logic                     r_bz [CORDIC_STEPS+1];
    logic                     r_ap [CORDIC_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]  <= $signed({{(CRD_W-ROOT_W-8){1'b0}}, i_b, 8'd0});
            r_y[0]  <= $signed({{(CRD_W-AXIS_W-16){i_a[AXIS_W-1]}}, i_a, 16'd0});
            r_z[0]  <= '0;
            r_az[0] <= (i_a == '0);
            r_bz[0] <= (i_b == '0);
            r_ap[0] <= !i_a[AXIS_W-1];
        end
    end

    for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_stage
        logic signed [CRD_W-1:0]  w_dx, w_dy;
        logic signed [ZACC_W+1:0] w_t;
        assign w_dx = r_y[s] >>> s;
        assign w_dy = r_x[s] >>> s;
        assign w_t  = $signed({2'b00, atan_entry(5'(s))});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_y[s][CRD_W-1]) begin
                    r_x[s+1] <= r_x[s] + w_dx;
                    r_y[s+1] <= r_y[s] - w_dy;
                    r_z[s+1] <= r_z[s] + w_t;
                end else begin
                    r_x[s+1] <= r_x[s] - w_dx;
                    r_y[s+1] <= r_y[s] + w_dy;
                    r_z[s+1] <= r_z[s] - w_t;
                end
                r_az[s+1] <= r_az[s];
                r_bz[s+1] <= r_bz[s];
                r_ap[s+1] <= r_ap[s];
            end
        end
    end

    // Round to nearest with ties away from zero, then clamp.
    logic signed [ZACC_W+1:0] w_zf;
    logic [ZACC_W+1:0]        w_mag, w_rnd;
    logic signed [ZACC_W+1:0] w_r;
    always_comb begin
        w_zf  = r_z[CORDIC_STEPS];
        w_mag = w_zf[ZACC_W+1] ? $unsigned(-w_zf) : $unsigned(w_zf);
        w_rnd = (w_mag + (ZACC_W+2)'(1 << (SH-1))) >> SH;
        if (w_rnd > (ZACC_W+2)'(LIMIT)) begin
            w_rnd = (ZACC_W+2)'(LIMIT);
        end
        w_r = w_zf[ZACC_W+1] ? -$signed(w_rnd) : $signed(w_rnd);
        if (r_az[CORDIC_STEPS]) begin
            o_angle = '0;
        end else if (r_bz[CORDIC_STEPS]) begin
            o_angle = r_ap[CORDIC_STEPS] ? ANGLE_W'(LIMIT) : ANGLE_W'(-LIMIT);
        end else begin
            o_angle = ANGLE_W'(w_r);
        end
    end

endmodule

// ===== sv/accel_tilt_pitch_roll.sv =====
// ----------------------------------------------------------------------------
// accel_tilt_pitch_roll
// Scales raw accelerometer counts to g and computes pitch and roll angles.
//
//  Channel | Direction | Handshake        | Payload
//  --------+-----------+------------------+------------------------------
//  in      | input     | valid / stall    | six raw data bytes
//  out     | output    | valid / stall    | x, y, z in g, pitch, roll
//  cfg     | input     | valid / ready    | register index, divisor
//
// Results pass through the bit-per-stage divider, square root and CORDIC pipes.
// One transaction is accepted per cycle while the output is not stalled.
// A stall from the output freezes the whole pipeline, so nothing is lost or
// repeated. Synchronous reset clears the valid bits and returns every divisor
// to 256; the config port is always ready.
// ----------------------------------------------------------------------------
module accel_tilt_pitch_roll
    import atpr_pkg::*;
#(
    parameter int G_FRAC_BITS     = G_FRAC_DEF,
    parameter int ANGLE_FRAC_BITS = ANG_FRAC_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [7:0]                i_x_low_byte,
    input  logic [7:0]                i_x_high_byte,
    input  logic [7:0]                i_y_low_byte,
    input  logic [7:0]                i_y_high_byte,
    input  logic [7:0]                i_z_low_byte,
    input  logic [7:0]                i_z_high_byte,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [AXIS_W-1:0]  o_x_in_g,
    output logic signed [AXIS_W-1:0]  o_y_in_g,
    output logic signed [AXIS_W-1:0]  o_z_in_g,
    output logic signed [ANGLE_W-1:0] o_pitch_degrees,
    output logic signed [ANGLE_W-1:0] o_roll_degrees,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [DIV_W-1:0]          i_cfg_data
);
    // Divider input register, one stage per quotient bit, scaled-axis register.
    localparam int DIV_LAT = AXIS_W + G_FRAC_BITS + 2;
    localparam int SQ_LAT  = ROOT_W + 2;
    localparam int CR_LAT  = CORDIC_STEPS + 1;
    localparam int LAT     = DIV_LAT + SQ_LAT + CR_LAT;

    localparam logic signed [ANGLE_W-1:0] ANG_MAX = ANGLE_W'(90 << ANGLE_FRAC_BITS);

    logic [DIV_W-1:0] r_div [CFG_COUNT];
    logic [LAT-1:0]   r_vld;
    logic             w_en;

    // Divisor registers.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CFG_COUNT; k++) begin
                r_div[k] <= DIV_W'(DIV_RESET);
            end
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_X_POS: r_div[0] <= i_cfg_data;
                CFG_X_NEG: r_div[1] <= i_cfg_data;
                CFG_Y_POS: r_div[2] <= i_cfg_data;
                CFG_Y_NEG: r_div[3] <= i_cfg_data;
                CFG_Z_POS: r_div[4] <= i_cfg_data;
                CFG_Z_NEG: r_div[5] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The pipe advances whenever the last stage is free or being taken.
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // Axis scaling.
    logic signed [AXIS_W-1:0] w_gx, w_gy, w_gz;
    atpr_div #(.G_FRAC_BITS(G_FRAC_BITS)) u_div_x (
        .i_clk(i_clk), .i_en(w_en),
        .i_count($signed({i_x_high_byte, i_x_low_byte})),
        .i_pos_div(r_div[0]), .i_neg_div(r_div[1]), .o_quot(w_gx));
    atpr_div #(.G_FRAC_BITS(G_FRAC_BITS)) u_div_y (
        .i_clk(i_clk), .i_en(w_en),
        .i_count($signed({i_y_high_byte, i_y_low_byte})),
        .i_pos_div(r_div[2]), .i_neg_div(r_div[3]), .o_quot(w_gy));
    atpr_div #(.G_FRAC_BITS(G_FRAC_BITS)) u_div_z (
        .i_clk(i_clk), .i_en(w_en),
        .i_count($signed({i_z_high_byte, i_z_low_byte})),
        .i_pos_div(r_div[4]), .i_neg_div(r_div[5]), .o_quot(w_gz));

    // Register scaled axes; they ride along with the rest of the pipe.
    logic signed [AXIS_W-1:0] r_gx [SQ_LAT+CR_LAT+1];
    logic signed [AXIS_W-1:0] r_gy [SQ_LAT+CR_LAT+1];
    logic signed [AXIS_W-1:0] r_gz [SQ_LAT+CR_LAT+1];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_gx[0] <= w_gx;
            r_gy[0] <= w_gy;
            r_gz[0] <= w_gz;
            for (int k = 1; k < SQ_LAT + CR_LAT + 1; k++) begin
                r_gx[k] <= r_gx[k-1];
                r_gy[k] <= r_gy[k-1];
                r_gz[k] <= r_gz[k-1];
            end
        end
    end

    // Denominators for pitch and roll.
    logic [ROOT_W-1:0] w_bp, w_br;
    atpr_sqrt u_sqrt_p (.i_clk(i_clk), .i_en(w_en), .i_p(r_gy[0]), .i_q(r_gz[0]),
                        .o_root(w_bp));
    atpr_sqrt u_sqrt_r (.i_clk(i_clk), .i_en(w_en), .i_p(r_gx[0]), .i_q(r_gz[0]),
                        .o_root(w_br));

    // Angles.
    atpr_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_cordic_p (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_gx[SQ_LAT]), .i_b(w_bp),
        .o_angle(o_pitch_degrees));
    atpr_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_cordic_r (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_gy[SQ_LAT]), .i_b(w_br),
        .o_angle(o_roll_degrees));

    assign o_x_in_g = r_gx[SQ_LAT+CR_LAT];
    assign o_y_in_g = r_gy[SQ_LAT+CR_LAT];
    assign o_z_in_g = r_gz[SQ_LAT+CR_LAT];

    // A stalled result must stay valid, with its pitch unchanged, until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pitch_degrees))
        else $error("result changed while stalled");
    // Pitch stays within plus or minus 90 degrees.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pitch_degrees <= ANG_MAX) && (o_pitch_degrees >= -ANG_MAX))
        else $error("pitch out of range");
    // Stall only while a result is waiting.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("stall without pending result");

endmodule

// ===== sim/accel_tilt_pitch_roll_checker.sv =====
// ----------------------------------------------------------------------------
// accel_tilt_pitch_roll_checker
// Watches the sample, result and divisor channels of the tilt block, works out
// the scaled axes and both tilt angles for every accepted sample, and compares
// each accepted result with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module accel_tilt_pitch_roll_checker
    import atpr_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic                      i_stall_in,
    input  logic [7:0]                i_x_low_byte,
    input  logic [7:0]                i_x_high_byte,
    input  logic [7:0]                i_y_low_byte,
    input  logic [7:0]                i_y_high_byte,
    input  logic [7:0]                i_z_low_byte,
    input  logic [7:0]                i_z_high_byte,
    input  logic                      i_res_valid,
    input  logic                      i_res_stall,
    input  logic signed [AXIS_W-1:0]  i_x_in_g,
    input  logic signed [AXIS_W-1:0]  i_y_in_g,
    input  logic signed [AXIS_W-1:0]  i_z_in_g,
    input  logic signed [ANGLE_W-1:0] i_pitch_degrees,
    input  logic signed [ANGLE_W-1:0] i_roll_degrees,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [DIV_W-1:0]          i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint RIGHT_ANGLE = 90 * 256;

    typedef struct packed {
        logic [15:0] x_g;
        logic [15:0] y_g;
        logic [15:0] z_g;
        logic [15:0] pitch;
        logic [15:0] roll;
    } t_tilt_result;

    // Arctangent of 2^-k in units of 2^-16 degree.
    longint atan_steps [20] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
    };

    logic [DIV_W-1:0] divisor [CFG_COUNT];
    t_tilt_result     expected_tilt [$];

    initial begin
        o_fail_count   = 0;
        o_result_count = 0;
    end

    assign o_pending = expected_tilt.size();

    // Integer square root, floor.
    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Raw count divided by the calibration divisor, Q4.12, saturated.
    function automatic longint scale_to_g(input logic [15:0] raw,
                                          input logic [DIV_W-1:0] pos_div,
                                          input logic [DIV_W-1:0] neg_div);
        longint cnt;
        longint d;
        longint q;
        cnt = longint'($signed(raw));
        d   = (cnt > 0) ? longint'(pos_div) : longint'(neg_div);
        if (d == 0) begin
            return (cnt > 0) ? 32767 : ((cnt < 0) ? -32768 : 0);
        end
        q = (cnt * 4096) / d;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q;
    endfunction

    // atan2(a, sqrt(p^2 + q^2)) in Q8.8 degrees by vectoring CORDIC.
    function automatic longint tilt_deg(input longint a, input longint p,
                                        input longint q);
        longint unsigned sum_sq;
        longint b;
        longint xc;
        longint yc;
        longint ang;
        longint dx;
        longint dy;
        longint mag;
        longint r;
        sum_sq = longint'(p * p) + longint'(q * q);
        b = longint'(floor_root(sum_sq << 16));
        if (a == 0) return 0;
        if (b == 0) return (a > 0) ? RIGHT_ANGLE : -RIGHT_ANGLE;
        xc  = b * 256;
        yc  = a * 65536;
        ang = 0;
        for (int k = 0; k < 20; k++) begin
            dx = yc >>> k;
            dy = xc >>> k;
            if (yc >= 0) begin
                xc  = xc + dx;
                yc  = yc - dy;
                ang = ang + atan_steps[k];
            end else begin
                xc  = xc - dx;
                yc  = yc + dy;
                ang = ang - atan_steps[k];
            end
        end
        // Round half away from zero down to eight fraction bits.
        mag = (ang < 0) ? -ang : ang;
        mag = (mag + 128) >> 8;
        r = (ang < 0) ? -mag : mag;
        if (r > RIGHT_ANGLE) r = RIGHT_ANGLE;
        if (r < -RIGHT_ANGLE) r = -RIGHT_ANGLE;
        return r;
    endfunction

    function automatic t_tilt_result predict_tilt(input logic [47:0] sample);
        t_tilt_result res;
        longint gx;
        longint gy;
        longint gz;
        gx = scale_to_g(sample[15:0], divisor[CFG_X_POS], divisor[CFG_X_NEG]);
        gy = scale_to_g(sample[31:16], divisor[CFG_Y_POS], divisor[CFG_Y_NEG]);
        gz = scale_to_g(sample[47:32], divisor[CFG_Z_POS], divisor[CFG_Z_NEG]);
        res.x_g   = gx[15:0];
        res.y_g   = gy[15:0];
        res.z_g   = gz[15:0];
        res.pitch = 16'(tilt_deg(gx, gy, gz));
        res.roll  = 16'(tilt_deg(gy, gx, gz));
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [15:0] want,
                                   input logic [15:0] got);
        $display("%0t: result %0d field %s expected %0d got %0d", $realtime,
                 o_result_count, field, $signed(want), $signed(got));
        o_fail_count++;
    endtask

    // Track divisor writes, predict on sample transactions, check results.
    always @(posedge i_clk) begin
        t_tilt_result want;
        if (!i_rst_n) begin
            for (int k = 0; k < CFG_COUNT; k++) divisor[k] <= DIV_W'(DIV_RESET);
        end else begin
            if (i_cfg_valid && i_cfg_ready && i_cfg_index < CFG_COUNT) begin
                divisor[i_cfg_index] <= i_cfg_data;
            end
            if (i_res_valid && !i_res_stall) begin
                if (expected_tilt.size() == 0) begin
                    $display("%0t: result with no sample outstanding", $realtime);
                    o_fail_count++;
                end else begin
                    want = expected_tilt.pop_front();
                    if (want.x_g !== i_x_in_g) report_mismatch("x_in_g", want.x_g, i_x_in_g);
                    if (want.y_g !== i_y_in_g) report_mismatch("y_in_g", want.y_g, i_y_in_g);
                    if (want.z_g !== i_z_in_g) report_mismatch("z_in_g", want.z_g, i_z_in_g);
                    if (want.pitch !== i_pitch_degrees) begin
                        report_mismatch("pitch", want.pitch, i_pitch_degrees);
                    end
                    if (want.roll !== i_roll_degrees) begin
                        report_mismatch("roll", want.roll, i_roll_degrees);
                    end
                end
                o_result_count++;
            end
            if (i_valid && !i_stall_in) begin
                expected_tilt.push_back(predict_tilt({i_z_high_byte, i_z_low_byte,
                                                      i_y_high_byte, i_y_low_byte,
                                                      i_x_high_byte, i_x_low_byte}));
            end
        end
    end

endmodule

// ===== sim/accel_tilt_pitch_roll_test.sv =====
// ----------------------------------------------------------------------------
// accel_tilt_pitch_roll_test
// Drives accelerometer samples and divisor settings into the tilt block with
// random idling and back-pressure; a checker beside the block predicts and
// compares every result.
// ----------------------------------------------------------------------------
module accel_tilt_pitch_roll_test;
    import atpr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASES        = 7;
    localparam int RANDOM_ITEMS  = 284;
    localparam int DRAIN_CYCLES  = 100;
    localparam int WATCHDOG      = 4000;
    localparam int LONG_HOLD     = 300;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx_raw;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic [7:0]                i_x_low_byte = '0;
    logic [7:0]                i_x_high_byte = '0;
    logic [7:0]                i_y_low_byte = '0;
    logic [7:0]                i_y_high_byte = '0;
    logic [7:0]                i_z_low_byte = '0;
    logic [7:0]                i_z_high_byte = '0;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic signed [AXIS_W-1:0]  o_x_in_g;
    logic signed [AXIS_W-1:0]  o_y_in_g;
    logic signed [AXIS_W-1:0]  o_z_in_g;
    logic signed [ANGLE_W-1:0] o_pitch_degrees;
    logic signed [ANGLE_W-1:0] o_roll_degrees;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [DIV_W-1:0]          i_cfg_data = '0;

    int fail_count;
    int pending;
    int result_count;
    int sample_count = 0;
    int idle_cycles = 0;
    bit quiet = 1'b0;
    bit hold_request = 1'b0;

    accel_tilt_pitch_roll u_dut (.*);

    accel_tilt_pitch_roll_checker u_checker (
        .i_clk, .i_rst_n, .i_valid,
        .i_stall_in      (o_stall),
        .i_x_low_byte, .i_x_high_byte, .i_y_low_byte,
        .i_y_high_byte, .i_z_low_byte, .i_z_high_byte,
        .i_res_valid     (o_valid),
        .i_res_stall     (i_stall),
        .i_x_in_g        (o_x_in_g),
        .i_y_in_g        (o_y_in_g),
        .i_z_in_g        (o_z_in_g),
        .i_pitch_degrees (o_pitch_degrees),
        .i_roll_degrees  (o_roll_degrees),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_result_count  (result_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Watchdog on cycles in which no transaction of any kind completes.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG) begin
            $display("watchdog expired with %0d results outstanding", pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side back-pressure: random bursts, one long hold when asked.
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 13);
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    // Raw count for one axis, leaning on extremes, small values and zero.
    function automatic logic [15:0] make_count();
        logic [15:0] ends [5] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000};
        case ($urandom_range(0, 7))
            0, 1, 2: return 16'($urandom);
            3, 4:    return 16'(int'($urandom_range(0, 600)) - 300);
            5:       return ends[$urandom_range(0, 4)];
            6:       return 16'h0000;
            default: return 16'(int'($urandom_range(0, 8192)) - 4096);
        endcase
    endfunction

    task automatic write_divisor(input t_cfg_idx_raw idx, input logic [DIV_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // Offer one sample; returns once it is taken, at times after a random idle gap.
    task automatic send_sample(input logic [15:0] x, input logic [15:0] y,
                               input logic [15:0] z);
        i_valid       <= 1'b1;
        i_x_low_byte  <= x[7:0];
        i_x_high_byte <= x[15:8];
        i_y_low_byte  <= y[7:0];
        i_y_high_byte <= y[15:8];
        i_z_low_byte  <= z[7:0];
        i_z_high_byte <= z[15:8];
        @(negedge i_clk);
        while (o_stall) @(negedge i_clk);
        @(posedge i_clk);
        sample_count++;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    initial begin
        logic [DIV_W-1:0] div_set [CFG_COUNT];
        logic [15:0] dir_x [12] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000,
                                    16'h7FFF, 16'h8000, 16'hFFFF, 16'h0100, 16'h00FF,
                                    16'hFF00, 16'h0001};
        logic [15:0] dir_y [12] = '{16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0000,
                                    16'h7FFF, 16'h8000, 16'h0001, 16'h0000, 16'hFF00,
                                    16'h00FF, 16'h8000};
        logic [15:0] dir_z [12] = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8000,
                                    16'h7FFF, 16'h8000, 16'h0000, 16'h0100, 16'h0000,
                                    16'h7FFF, 16'h0001};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset divisors first with the directed corner samples.
        for (int k = 0; k < 12; k++) send_sample(dir_x[k], dir_y[k], dir_z[k]);

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_results();
            quiet = (ph == PHASES - 1);
            for (int k = 0; k < CFG_COUNT; k++) begin
                case (ph)
                    0:       div_set[k] = DIV_W'(DIV_RESET);
                    1:       div_set[k] = 12'd1;
                    2:       div_set[k] = 12'd4095;
                    3:       div_set[k] = 12'd0;
                    4:       div_set[k] = 12'($urandom_range(1, 4095));
                    5:       div_set[k] = 12'($urandom_range(1, 64));
                    default: div_set[k] = 12'($urandom_range(0, 4095));
                endcase
            end
            if (ph > 0) begin
                for (int k = 0; k < CFG_COUNT; k++) write_divisor(t_cfg_idx_raw'(k), div_set[k]);
                // Indexes past the last register must leave everything alone.
                write_divisor(t_cfg_idx_raw'(6), 12'($urandom));
                write_divisor(t_cfg_idx_raw'(7), 12'($urandom));
                i_cfg_valid <= 1'b0;
                @(posedge i_clk);
            end
            if (ph == 2) hold_request = 1'b1;
            if (ph == 3) begin
                send_sample(16'h0000, 16'h0001, 16'hFFFF);
                send_sample(16'h7FFF, 16'h8000, 16'h0000);
            end
            for (int k = 0; k < RANDOM_ITEMS; k++) send_sample(make_count(), make_count(), make_count());
        end
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d samples, %0d results checked, over %0d divisor settings", sample_count,
                 result_count, PHASES);
        $display("Settings included unit, full-scale, zero and random divisors.");
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/atpr_pkg.sv
sv/atpr_div.sv
sv/atpr_sqrt.sv
sv/atpr_cordic.sv
sv/accel_tilt_pitch_roll.sv
sim/accel_tilt_pitch_roll_checker.sv
sim/accel_tilt_pitch_roll_test.sv
